[sv/asba_pkg.sv]
// Shared types and constants for the ADC scan block averager.
// Used by asba_ctrl, asba_dpath, the core top level and its checker.
package asba_pkg;

  localparam int ADC_W   = 12;
  localparam int SUM_W   = 20;
  localparam int CNT_W   = 8;
  localparam int SLOT_W  = 3;
  localparam int CHAN_W  = 3;
  localparam int UV_W    = 28;
  localparam int SCALE_W = 24;
  localparam int PROD_W  = ADC_W + SCALE_W;
  localparam int UV_SHIFT = 8;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_CNT_W = 5;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_RESULT = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_AVG  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS_NEEDED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q8      = 3'd4;

  localparam logic [3:0]         RST_SLOT_COUNT    = 4'd2;
  localparam logic [23:0]        RST_CHANNEL_MAP   = 24'd60;
  localparam logic [CNT_W-1:0]   RST_FILTER_LEN    = 8'd10;
  localparam logic [CNT_W-1:0]   RST_ROUNDS_NEEDED = 8'd20;
  localparam logic [SCALE_W-1:0] RST_SCALE_Q8      = 24'd156250;

  localparam logic [CNT_W-1:0] RND_MAX = 8'd255;

  typedef struct packed {
    logic [3:0]         slot_count;
    logic [23:0]        channel_map;
    logic [CNT_W-1:0]   filter_len;
    logic [CNT_W-1:0]   rounds_needed;
    logic [SCALE_W-1:0] scale_q8;
  } asba_cfg_t;

  typedef struct packed {
    logic              clear;
    logic              wr_latest;
    logic              acc;
    logic              take;
    logic              div_step;
    logic              mul;
    logic              load_out;
    logic [1:0]        kind;
    logic              last;
    logic [SLOT_W-1:0] idx;
  } asba_cmd_t;

  typedef struct packed {
    logic fire;
    logic round_short;
    logic out_free;
  } asba_sts_t;

endpackage

[sv/asba_dpath.sv]
// Datapath of the ADC scan block averager: per-slot stores, serial divider,
// scale multiplier and output register. Depends on asba_pkg.
module asba_dpath #(
  parameter int MAX_SLOTS = 8,
  parameter int CODE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  asba_pkg::asba_cfg_t           cfg,
  input  asba_pkg::asba_cmd_t           cmd,
  input  logic [asba_pkg::ADC_W-1:0]    code,
  output asba_pkg::asba_sts_t           sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [1:0]                    out_kind,
  output logic [asba_pkg::SLOT_W-1:0]   out_slot,
  output logic [asba_pkg::CHAN_W-1:0]   out_chan,
  output logic [asba_pkg::ADC_W-1:0]    out_avg_code,
  output logic [asba_pkg::UV_W-1:0]     out_microvolts,
  output logic                          out_last
);
  import asba_pkg::*;

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LC_W  = (CODE_BITS < ADC_W) ? CODE_BITS : ADC_W;

  logic [LC_W-1:0]  latest_r [MAX_SLOTS];
  logic [SUM_W-1:0] sum_r    [MAX_SLOTS];
  logic [CNT_W-1:0] cnt_r    [MAX_SLOTS];
  logic [CNT_W-1:0] rnd_r    [MAX_SLOTS];

  logic [IDX_W-1:0] idx;
  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] dvs_r;
  logic [CNT_W:0]   trial;
  logic             ge;
  logic [PROD_W-1:0] prod_r;
  logic             out_valid_r;
  logic [1:0]       kind_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CHAN_W-1:0] chan_r;
  logic [ADC_W-1:0] avg_r;
  logic [UV_W-1:0]  uv_r;
  logic             last_r;
  logic             is_done;
  logic             is_avg;

  assign idx = cmd.idx[IDX_W-1:0];

  assign sts.fire        = (cnt_r[idx] >= cfg.filter_len) && (cnt_r[idx] != '0);
  assign sts.round_short = rnd_r[idx] < cfg.rounds_needed;
  assign sts.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        latest_r[i] <= '0;
        sum_r[i]    <= '0;
        cnt_r[i]    <= '0;
        rnd_r[i]    <= '0;
      end
    end else begin
      if (cmd.wr_latest) begin
        latest_r[idx] <= code[LC_W-1:0];
      end
      if (cmd.acc) begin
        cnt_r[idx] <= cnt_r[idx] + 8'd1;
        sum_r[idx] <= sum_r[idx] + SUM_W'(latest_r[idx]);
      end
      if (cmd.take) begin
        cnt_r[idx] <= '0;
        sum_r[idx] <= '0;
        if (rnd_r[idx] != RND_MAX) begin
          rnd_r[idx] <= rnd_r[idx] + 8'd1;
        end
      end
    end
  end

  assign trial   = {rem_r, quo_r[SUM_W-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign rem_nxt = ge ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
  assign quo_nxt = {quo_r[SUM_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      quo_r <= sum_r[idx];
      rem_r <= '0;
      dvs_r <= cnt_r[idx];
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(quo_r[ADC_W-1:0]) * PROD_W'(cfg.scale_q8);
    end
  end

  assign is_done = cmd.kind == KIND_DONE;
  assign is_avg  = cmd.kind == KIND_AVG;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kind_r <= cmd.kind;
      slot_r <= is_done ? '0 : cmd.idx;
      chan_r <= is_done ? '0 : cfg.channel_map[5'(cmd.idx) * 5'd3 +: CHAN_W];
      avg_r  <= is_avg ? quo_r[ADC_W-1:0] : '0;
      uv_r   <= is_avg ? prod_r[UV_SHIFT +: UV_W] : '0;
      last_r <= cmd.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_slot       = slot_r;
  assign out_chan       = chan_r;
  assign out_avg_code   = avg_r;
  assign out_microvolts = uv_r;
  assign out_last       = last_r;

endmodule

[sv/asba_ctrl.sv]
// Controller of the ADC scan block averager: request decode, scan position,
// round-end slot walk and result sequencing. Depends on asba_pkg.
module asba_ctrl #(
  parameter int MAX_SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [3:0]           slot_count,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_opcode,
  input  asba_pkg::asba_sts_t  sts,
  output asba_pkg::asba_cmd_t  cmd
);
  import asba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_REQ, S_ACC, S_TEST, S_DIV, S_MUL, S_AVG, S_STEP, S_FINAL
  } state_t;

  state_t                 state_r;
  logic                   running_r;
  logic [3:0]             scan_slot_r;
  logic [SLOT_W-1:0]      walk_r;
  logic [DIV_CNT_W-1:0]   bit_cnt_r;
  logic                   all_done_r;
  logic [3:0]             n_eff;
  logic [3:0]             slot_inc;
  logic [3:0]             walk_inc;
  logic                   accept;

  assign n_eff = (slot_count == 4'd0) ? 4'd1 :
                 (slot_count > 4'(MAX_SLOTS)) ? 4'(MAX_SLOTS) : slot_count;
  assign slot_inc = scan_slot_r + 4'd1;
  assign walk_inc = {1'b0, walk_r} + 4'd1;
  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.idx = walk_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.idx = scan_slot_r[SLOT_W-1:0];
        if (accept) begin
          cmd.clear     = in_opcode == OP_START;
          cmd.wr_latest = (in_opcode == OP_RESULT) && running_r;
        end
      end
      S_REQ: begin
        cmd.idx      = scan_slot_r[SLOT_W-1:0];
        cmd.kind     = KIND_REQ;
        cmd.last     = 1'b1;
        cmd.load_out = sts.out_free;
      end
      S_ACC:  cmd.acc = 1'b1;
      S_TEST: cmd.take = sts.fire;
      S_DIV:  cmd.div_step = 1'b1;
      S_MUL:  cmd.mul = 1'b1;
      S_AVG: begin
        cmd.kind     = KIND_AVG;
        cmd.load_out = sts.out_free;
      end
      S_STEP: cmd.acc = 1'b0;
      S_FINAL: begin
        cmd.idx      = '0;
        cmd.kind     = all_done_r ? KIND_DONE : KIND_REQ;
        cmd.last     = 1'b1;
        cmd.load_out = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= 1'b0;
      scan_slot_r <= '0;
      walk_r      <= '0;
      bit_cnt_r   <= '0;
      all_done_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_opcode)
              OP_START: begin
                scan_slot_r <= '0;
                running_r   <= 1'b1;
                state_r     <= S_REQ;
              end
              OP_STOP: running_r <= 1'b0;
              OP_RESULT: begin
                if (running_r) begin
                  if (slot_inc < n_eff) begin
                    scan_slot_r <= slot_inc;
                    state_r     <= S_REQ;
                  end else begin
                    scan_slot_r <= '0;
                    walk_r      <= '0;
                    all_done_r  <= 1'b1;
                    state_r     <= S_ACC;
                  end
                end
              end
              default: running_r <= running_r;
            endcase
          end
        end
        S_REQ: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_ACC: state_r <= S_TEST;
        S_TEST: begin
          bit_cnt_r <= '0;
          state_r   <= sts.fire ? S_DIV : S_STEP;
        end
        S_DIV: begin
          bit_cnt_r <= bit_cnt_r + 5'd1;
          if (bit_cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_AVG;
        S_AVG: begin
          if (sts.out_free) begin
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          if (sts.round_short) begin
            all_done_r <= 1'b0;
          end
          if (walk_inc < n_eff) begin
            walk_r  <= walk_inc[SLOT_W-1:0];
            state_r <= S_ACC;
          end else begin
            state_r <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (sts.out_free) begin
            if (all_done_r) begin
              running_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/adc_scan_block_averager_core.sv]
// Top level of the ADC scan block averager: configuration registers and
// the controller/datapath pair. Depends on asba_pkg, asba_ctrl, asba_dpath.
//
//   channel  | direction | handshake             | payload
//   in_      | in        | in_valid / in_ready   | in_opcode, in_adc_code
//   out_     | out       | out_valid / out_ready | out_kind, out_slot,
//            |           |                       | out_chan, out_avg_code,
//            |           |                       | out_microvolts, out_last
//   cfg_     | in        | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// A start or mid-round request hands a conversion request to the output
// register; a stop or an ignored request produces no result. A round-end
// request walks the slots one per pass; a slot whose average is due also runs
// the radix-2 serial divider, one multiply and an output step, and the final
// result follows the walk. Output stalls hold the sequence. Reset is
// synchronous and active low; no clearing pass is needed.
module adc_scan_block_averager_core #(
  parameter int MAX_SLOTS = 8,
  parameter int CODE_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_opcode,
  input  logic [asba_pkg::ADC_W-1:0]         in_adc_code,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_kind,
  output logic [asba_pkg::SLOT_W-1:0]        out_slot,
  output logic [asba_pkg::CHAN_W-1:0]        out_chan,
  output logic [asba_pkg::ADC_W-1:0]         out_avg_code,
  output logic [asba_pkg::UV_W-1:0]          out_microvolts,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [asba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asba_pkg::CFG_W-1:0]         cfg_wdata
);
  import asba_pkg::*;

  asba_cfg_t cfg_r;
  asba_cmd_t cmd;
  asba_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slot_count    <= RST_SLOT_COUNT;
      cfg_r.channel_map   <= RST_CHANNEL_MAP;
      cfg_r.filter_len    <= RST_FILTER_LEN;
      cfg_r.rounds_needed <= RST_ROUNDS_NEEDED;
      cfg_r.scale_q8      <= RST_SCALE_Q8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOT_COUNT:    cfg_r.slot_count    <= cfg_wdata[3:0];
        REG_CHANNEL_MAP:   cfg_r.channel_map   <= cfg_wdata[23:0];
        REG_FILTER_LEN:    cfg_r.filter_len    <= cfg_wdata[CNT_W-1:0];
        REG_ROUNDS_NEEDED: cfg_r.rounds_needed <= cfg_wdata[CNT_W-1:0];
        REG_SCALE_Q8:      cfg_r.scale_q8      <= cfg_wdata[SCALE_W-1:0];
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  asba_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .slot_count (cfg_r.slot_count),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .sts        (sts),
    .cmd        (cmd)
  );

  asba_dpath #(
    .MAX_SLOTS (MAX_SLOTS),
    .CODE_BITS (CODE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .code            (in_adc_code),
    .sts             (sts),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_slot        (out_slot),
    .out_chan        (out_chan),
    .out_avg_code    (out_avg_code),
    .out_microvolts  (out_microvolts),
    .out_last        (out_last)
  );

endmodule

[sv/asba_checker.sv]
// Port-level checks for adc_scan_block_averager_core, bound to the top level.
// Depends on asba_pkg.
module asba_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         out_kind,
  input logic [asba_pkg::SLOT_W-1:0]        out_slot,
  input logic [asba_pkg::CHAN_W-1:0]        out_chan,
  input logic [asba_pkg::ADC_W-1:0]         out_avg_code,
  input logic [asba_pkg::UV_W-1:0]          out_microvolts,
  input logic                               out_last
);
  import asba_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_slot)
      && $stable(out_chan) && $stable(out_avg_code)
      && $stable(out_microvolts) && $stable(out_last))
    else $error("output request changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE |-> out_last && out_slot == '0
      && out_chan == '0 && out_avg_code == '0 && out_microvolts == '0)
    else $error("done request not final or not cleared");

  a_req_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_REQ |-> out_last && out_avg_code == '0
      && out_microvolts == '0)
    else $error("conversion request malformed");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind adc_scan_block_averager_core asba_checker u_asba_checker (.*);

[dv/adc_scan_block_averager_core_test.sv]
// Self-checking testbench for adc_scan_block_averager_core: a scan predictor
// built from the package types checks every result of directed and random scans.
// Depends on asba_pkg and the core RTL only.
module adc_scan_block_averager_core_test;
  import asba_pkg::*;

  localparam int SCAN_SLOTS = 8;
  localparam int RANDOM_REQUESTS = 160;
  localparam int SETTLE_CYCLES = 32;
  localparam int TAIL_CYCLES = 250;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [CHAN_W-1:0] chan;
    logic [ADC_W-1:0]  avg;
    logic [UV_W-1:0]   uv;
    logic              last;
  } scan_result_t;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_MOSTLY} ready_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = OP_START;
  logic [ADC_W-1:0] in_adc_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [SLOT_W-1:0] out_slot;
  logic [CHAN_W-1:0] out_chan;
  logic [ADC_W-1:0] out_avg_code;
  logic [UV_W-1:0] out_microvolts;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SLOT_COUNT;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic [3:0]         cfg_slots = RST_SLOT_COUNT;
  logic [23:0]        cfg_chan_map = RST_CHANNEL_MAP;
  logic [CNT_W-1:0]   cfg_filter_len = RST_FILTER_LEN;
  logic [CNT_W-1:0]   cfg_rounds_needed = RST_ROUNDS_NEEDED;
  logic [SCALE_W-1:0] cfg_scale = RST_SCALE_Q8;

  logic             scan_running = 1'b0;
  logic [3:0]       scan_pos = '0;
  logic [ADC_W-1:0] slot_latest [SCAN_SLOTS];
  logic [SUM_W-1:0] slot_sum [SCAN_SLOTS];
  logic [CNT_W-1:0] slot_samples [SCAN_SLOTS];
  logic [CNT_W-1:0] slot_rounds [SCAN_SLOTS];

  scan_result_t results_due [$];

  int errors = 0;
  int requests_accepted = 0;
  int busy_requests = 0;
  int results_checked = 0;
  int averages_checked = 0;
  int scans_done = 0;
  int burst_left = 0;
  int ready_tick = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;

  adc_scan_block_averager_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_adc_code     (in_adc_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_slot        (out_slot),
    .out_chan        (out_chan),
    .out_avg_code    (out_avg_code),
    .out_microvolts  (out_microvolts),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < SCAN_SLOTS; i++) begin
      slot_latest[i] = '0;
      slot_sum[i] = '0;
      slot_samples[i] = '0;
      slot_rounds[i] = '0;
    end
  end

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_SLOT_COUNT:    cfg_slots = val[3:0];
      REG_CHANNEL_MAP:   cfg_chan_map = val[23:0];
      REG_FILTER_LEN:    cfg_filter_len = val[CNT_W-1:0];
      REG_ROUNDS_NEEDED: cfg_rounds_needed = val[CNT_W-1:0];
      REG_SCALE_Q8:      cfg_scale = val[SCALE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void queue_result(logic [1:0] kind, logic [SLOT_W-1:0] slot,
                                       logic [ADC_W-1:0] avg, logic [UV_W-1:0] uv);
    scan_result_t r;
    r.kind = kind;
    r.slot = (kind == KIND_DONE) ? '0 : slot;
    r.chan = (kind == KIND_DONE) ? '0 : CHAN_W'(cfg_chan_map >> (CHAN_W * slot));
    r.avg = avg;
    r.uv = uv;
    r.last = 1'b0;
    results_due.push_back(r);
  endfunction

  function automatic void advance_scan(logic [1:0] op, logic [ADC_W-1:0] code);
    int n;
    int first;
    logic all_done;
    logic [ADC_W-1:0] avg;
    logic [PROD_W-1:0] prod;
    scan_result_t r;
    n = (cfg_slots == 4'd0) ? 1 :
        (int'(cfg_slots) > SCAN_SLOTS) ? SCAN_SLOTS : int'(cfg_slots);
    first = results_due.size();
    case (op)
      OP_START: begin
        for (int i = 0; i < SCAN_SLOTS; i++) begin
          slot_latest[i] = '0;
          slot_sum[i] = '0;
          slot_samples[i] = '0;
          slot_rounds[i] = '0;
        end
        scan_pos = '0;
        scan_running = 1'b1;
        queue_result(KIND_REQ, '0, '0, '0);
      end
      OP_STOP: scan_running = 1'b0;
      OP_RESULT: if (scan_running) begin
        slot_latest[scan_pos[SLOT_W-1:0]] = code;
        scan_pos = scan_pos + 4'd1;
        if (int'(scan_pos) < n) begin
          queue_result(KIND_REQ, scan_pos[SLOT_W-1:0], '0, '0);
        end else begin
          for (int i = 0; i < n; i++) begin
            slot_samples[i] = slot_samples[i] + 8'd1;
            slot_sum[i] = slot_sum[i] + SUM_W'(slot_latest[i]);
            if (slot_samples[i] >= cfg_filter_len && slot_samples[i] != '0) begin
              avg = ADC_W'(slot_sum[i] / SUM_W'(slot_samples[i]));
              prod = PROD_W'(avg) * PROD_W'(cfg_scale);
              queue_result(KIND_AVG, SLOT_W'(i), avg, prod[UV_SHIFT +: UV_W]);
              if (slot_rounds[i] != RND_MAX) slot_rounds[i] = slot_rounds[i] + 8'd1;
              slot_samples[i] = '0;
              slot_sum[i] = '0;
            end
          end
          scan_pos = '0;
          all_done = 1'b1;
          for (int i = 0; i < n; i++)
            if (slot_rounds[i] < cfg_rounds_needed) all_done = 1'b0;
          if (all_done) begin
            scan_running = 1'b0;
            queue_result(KIND_DONE, '0, '0, '0);
          end else begin
            queue_result(KIND_REQ, '0, '0, '0);
          end
        end
      end
      default: ;
    endcase
    if (results_due.size() > first) begin
      r = results_due.pop_back();
      r.last = 1'b1;
      results_due.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    scan_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("kind: expected no result, got %0d", out_kind);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("slot", 32'(want.slot), 32'(out_slot));
        check_field("chan", 32'(want.chan), 32'(out_chan));
        check_field("avg_code", 32'(want.avg), 32'(out_avg_code));
        check_field("microvolts", 32'(want.uv), 32'(out_microvolts));
        check_field("last", 32'(want.last), 32'(out_last));
        results_checked++;
        if (want.kind == KIND_AVG) averages_checked++;
        if (want.kind == KIND_DONE) scans_done++;
      end
    end
  end

  always @(posedge clk) begin
    ready_tick++;
    if (ready_tick % 64 == 0) ready_mode = ready_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready <= (ready_tick % 8 == 0);
      default:    out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_request(logic [1:0] op, logic [ADC_W-1:0] code);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_adc_code <= code;
    do @(posedge clk); while (!in_ready);
    advance_scan(op, code);
    requests_accepted++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic load_config(logic [3:0] slots, logic [23:0] chan_map,
                             logic [CNT_W-1:0] filter_len, logic [CNT_W-1:0] rounds,
                             logic [SCALE_W-1:0] scale);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SLOT_COUNT, CFG_W'(slots));
    write_reg(REG_CHANNEL_MAP, CFG_W'(chan_map));
    write_reg(REG_FILTER_LEN, CFG_W'(filter_len));
    write_reg(REG_ROUNDS_NEEDED, CFG_W'(rounds));
    write_reg(REG_SCALE_Q8, CFG_W'(scale));
    cfg_we <= 1'b0;
  endtask

  task automatic test_default_config();
    send_request(OP_START, '0);
    send_request(OP_RESULT, 12'hFFF);
    send_request(OP_RESULT, 12'h000);
  endtask

  task automatic test_idle_opcodes();
    send_request(OP_STOP, '0);
    send_request(OP_RESULT, 12'h5A5);
    send_request(OP_STOP, 12'hA5A);
    send_request(OP_UNUSED, 12'hFFF);
    send_request(OP_START, '0);
    send_request(OP_START, '0);
    send_request(OP_UNUSED, 12'h123);
    send_request(OP_RESULT, 12'h800);
    send_request(OP_STOP, '0);
  endtask

  task automatic test_field_extremes();
    load_config(4'hF, 24'($urandom), 8'd1, 8'd1, 24'hFFFFFF);
    send_request(OP_START, '0);
    for (int i = 0; i < SCAN_SLOTS; i++)
      send_request(OP_RESULT, (i % 2 == 0) ? 12'hFFF : 12'h000);
    load_config(4'd0, 24'd0, 8'd0, 8'd0, 24'd0);
    send_request(OP_START, '0);
    send_request(OP_RESULT, 12'hFFF);
  endtask

  task automatic test_slot_shrink();
    load_config(4'd6, 24'hFAC688, 8'd1, 8'd255, RST_SCALE_Q8);
    send_request(OP_START, '0);
    repeat (4) send_request(OP_RESULT, 12'($urandom));
    load_config(4'd3, 24'hFAC688, 8'd255, 8'd255, RST_SCALE_Q8);
    send_request(OP_RESULT, 12'($urandom));
    load_config(4'd3, 24'hFAC688, 8'd1, 8'd255, RST_SCALE_Q8);
    repeat (3) send_request(OP_RESULT, 12'($urandom));
  endtask

  task automatic test_random_scans();
    logic [3:0] slots;
    logic [CNT_W-1:0] filter_len;
    logic [CNT_W-1:0] rounds;
    logic [SCALE_W-1:0] scale;
    logic [1:0] op;
    logic [ADC_W-1:0] code;
    int pick;
    logic counts;
    while (busy_requests < RANDOM_REQUESTS) begin
      slots = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
      pick = $urandom_range(0, 9);
      filter_len = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 3));
      pick = $urandom_range(0, 9);
      rounds = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 3));
      pick = $urandom_range(0, 9);
      scale = (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFFFFFF : 24'($urandom);
      load_config(slots, 24'($urandom), filter_len, rounds, scale);
      repeat ($urandom_range(15, 40)) begin
        if ($urandom_range(0, 19) == 0) wait_for_results();
        pick = $urandom_range(0, 99);
        if (!scan_running)
          op = (pick < 80) ? OP_START : (pick < 88) ? OP_RESULT :
               (pick < 94) ? OP_STOP : OP_UNUSED;
        else
          op = (pick < 88) ? OP_RESULT : (pick < 92) ? OP_START :
               (pick < 96) ? OP_STOP : OP_UNUSED;
        pick = $urandom_range(0, 9);
        code = (pick == 0) ? 12'h000 : (pick == 1) ? 12'hFFF : 12'($urandom);
        counts = scan_running ? (op != OP_UNUSED) : (op == OP_START);
        send_request(op, code);
        if (counts) busy_requests++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_default_config();
    test_idle_opcodes();
    test_field_extremes();
    test_slot_shrink();
    test_random_scans();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests over directed and random scan settings;", requests_accepted);
    $display("checked %0d results: %0d averages, %0d finished scans.",
             results_checked, averages_checked, scans_done);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results still outstanding", results_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
sv/asba_pkg.sv
sv/asba_dpath.sv
sv/asba_ctrl.sv
sv/adc_scan_block_averager_core.sv
sv/asba_checker.sv
dv/adc_scan_block_averager_core_test.sv
